// File: rtl/core/ps2db_pkg.sv
// Package for the PS/2 device bring-up sequencer.
// Holds the item and result types, state codes, register indexes and command bytes.
// No dependencies.
package ps2db_pkg;

    localparam int MAX_TRIES_DEF = 3;
    localparam int FIFO_DEPTH_DEF = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TRY_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL0_OK = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL1_OK = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_CODE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BAT_PASS_CODE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ID_ABSENT_CODE = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_NO_DEVICE_CODE = 3'd6;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1;
    localparam logic [7:0] ACK_RESET = 8'hFA;
    localparam logic [7:0] BAT_PASS_RESET = 8'hAA;
    localparam logic [15:0] ID_ABSENT_RESET = 16'hFFFE;
    localparam logic [15:0] NO_DEVICE_ID = 16'hFFFF;

    localparam logic [7:0] CMD_RESET = 8'hFF;
    localparam logic [7:0] CMD_DISABLE_SCAN = 8'hF5;
    localparam logic [7:0] CMD_IDENTIFY = 8'hF2;

    typedef enum logic [1:0] {
        KIND_START_RESET = 2'd0,
        KIND_START_IDENT = 2'd1,
        KIND_RX_BYTE     = 2'd2,
        KIND_TICK        = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ACT_ENABLE     = 3'd0,
        ACT_ROUTE      = 3'd1,
        ACT_SEND       = 3'd2,
        ACT_RESET_DONE = 3'd3,
        ACT_IDENT_DONE = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_BAD_ACK  = 3'd2,
        ST_BAT_FAIL = 3'd3,
        ST_BUSY     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_SEND  = 4'd1,
        PH_RST_ACK   = 4'd2,
        PH_RST_BAT   = 4'd3,
        PH_DIS_SEND  = 4'd4,
        PH_DIS_ACK   = 4'd5,
        PH_IDF_SEND  = 4'd6,
        PH_IDF_ACK   = 4'd7,
        PH_ID_FIRST  = 4'd8,
        PH_ID_SECOND = 4'd9
    } phase_t;

    // Classified input item as it travels from the front to the sequencer.
    typedef struct packed {
        kind_t      kind;
        logic       channel;
        logic       start_ok;
        logic [7:0] rx_byte;
        logic       is_ack;
        logic       is_bat_pass;
        logic       tx_busy;
    } item_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [15:0] id_absent_code;
    } seq_cfg_t;

    typedef struct packed {
        action_t     action;
        logic        out_channel;
        logic [7:0]  tx_byte;
        status_t     status;
        logic [15:0] device_id;
        logic        last;
    } result_t;

    function automatic result_t make_result(action_t act, logic ch, logic [7:0] tx,
                                            status_t st, logic [15:0] id);
        result_t r;
        r.action = act;
        r.out_channel = ch;
        r.tx_byte = tx;
        r.status = st;
        r.device_id = id;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

// File: rtl/core/ps2_device_bringup_sequencer_unit.sv
// Top level of the PS/2 device bring-up sequencer for two channels.
// Depends on ps2db_pkg, ps2db_front, ps2db_seq and ps2db_fifo.
//
//   Channel   Handshake         Payload
//   -------   ---------------   --------------------------------------------------
//   input     push / full       kind, channel, rx_byte, tx_busy
//   result    pop / empty       action, out_channel, tx_byte, status, device_id, last
//   config    cfg_write         cfg_index, cfg_data
//
// An item that causes two results is held in the sequencer until both are written, as
// the output queue has a single write port. An item's last result enters the result
// queue in the same cycle that the item is popped from the input queue.
// Reset clears the state, sets the configuration registers to their defaults and
// marks both stored device IDs as no device. A full result queue stalls the
// sequencer, which then backs up the input queue until full rises.
module ps2_device_bringup_sequencer_unit #(
    parameter int MAX_TRIES  = ps2db_pkg::MAX_TRIES_DEF,
    parameter int FIFO_DEPTH = ps2db_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [ps2db_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ps2db_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 push,
    output logic                                 full,
    input  logic [1:0]                           kind,
    input  logic                                 channel,
    input  logic [7:0]                           rx_byte,
    input  logic                                 tx_busy,
    input  logic                                 pop,
    output logic                                 empty,
    output logic [2:0]                           action,
    output logic                                 out_channel,
    output logic [7:0]                           tx_byte,
    output logic [2:0]                           status,
    output logic [15:0]                          device_id,
    output logic                                 last
);
    import ps2db_pkg::*;

    seq_cfg_t seq_cfg;
    logic     item_valid;
    item_t    item;
    logic     item_pop;
    logic     res_full;
    logic     res_push;
    result_t  res_in;
    result_t  res_out;

    ps2db_front #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .kind       (kind),
        .channel    (channel),
        .rx_byte    (rx_byte),
        .tx_busy    (tx_busy),
        .full       (full),
        .seq_cfg    (seq_cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    ps2db_seq #(
        .MAX_TRIES (MAX_TRIES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .seq_cfg    (seq_cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .out_full   (res_full),
        .out_push   (res_push),
        .out_data   (res_in)
    );

    ps2db_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_out),
        .empty     (empty)
    );

    assign action = res_out.action;
    assign out_channel = res_out.out_channel;
    assign tx_byte = res_out.tx_byte;
    assign status = res_out.status;
    assign device_id = res_out.device_id;
    assign last = res_out.last;

endmodule

// File: rtl/core/ps2db_fifo.sv
// Small generic first-in first-out queue built from flip-flops.
// Used for the input side and the result side of the sequencer. No dependencies.
module ps2db_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/ps2db_front.sv
// Front end: configuration registers, item classification and the input queue.
// Depends on ps2db_pkg and ps2db_fifo.
module ps2db_front #(
    parameter int FIFO_DEPTH = ps2db_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [ps2db_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ps2db_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 push,
    input  logic [1:0]                           kind,
    input  logic                                 channel,
    input  logic [7:0]                           rx_byte,
    input  logic                                 tx_busy,
    output logic                                 full,
    output ps2db_pkg::seq_cfg_t                  seq_cfg,
    output logic                                 item_valid,
    output ps2db_pkg::item_t                     item,
    input  logic                                 item_pop
);
    import ps2db_pkg::*;

    logic        ch0_ok_reg;
    logic        ch1_ok_reg;
    logic [15:0] timeout_reg;
    logic [7:0]  ack_reg;
    logic [7:0]  bat_pass_reg;
    logic [15:0] id_absent_reg;
    item_t       item_in;
    logic        item_empty;

    // The no-device code only sets the stored IDs at reset, so a later write
    // to that index has no effect and needs no register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch0_ok_reg <= 1'b0;
            ch1_ok_reg <= 1'b0;
            timeout_reg <= TIMEOUT_RESET;
            ack_reg <= ACK_RESET;
            bat_pass_reg <= BAT_PASS_RESET;
            id_absent_reg <= ID_ABSENT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CHANNEL0_OK:    ch0_ok_reg <= cfg_data[0];
                REG_CHANNEL1_OK:    ch1_ok_reg <= cfg_data[0];
                REG_TIMEOUT_TICKS:  timeout_reg <= cfg_data;
                REG_ACK_CODE:       ack_reg <= cfg_data[7:0];
                REG_BAT_PASS_CODE:  bat_pass_reg <= cfg_data[7:0];
                REG_ID_ABSENT_CODE: id_absent_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        item_in.kind = kind_t'(kind);
        item_in.channel = channel;
        item_in.start_ok = channel ? ch1_ok_reg : ch0_ok_reg;
        item_in.rx_byte = rx_byte;
        item_in.is_ack = (rx_byte == ack_reg);
        item_in.is_bat_pass = (rx_byte == bat_pass_reg);
        item_in.tx_busy = tx_busy;
    end

    assign seq_cfg.timeout_ticks = timeout_reg;
    assign seq_cfg.id_absent_code = id_absent_reg;

    ps2db_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_in_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (item_in),
        .full      (full),
        .pop       (item_pop),
        .pop_data  (item),
        .empty     (item_empty)
    );

    assign item_valid = !item_empty;

endmodule

// File: rtl/core/ps2db_seq.sv
// Back end: the bring-up state machine that turns classified items into results.
// Emits at most one result per cycle, none while the result queue is full. Depends on ps2db_pkg.
module ps2db_seq #(
    parameter int MAX_TRIES = ps2db_pkg::MAX_TRIES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ps2db_pkg::seq_cfg_t   seq_cfg,
    input  logic                  item_valid,
    input  ps2db_pkg::item_t      item,
    output logic                  item_pop,
    input  logic                  out_full,
    output logic                  out_push,
    output ps2db_pkg::result_t    out_data
);
    import ps2db_pkg::*;

    phase_t           phase_reg, phase_next;
    logic             op_reg, op_next;
    logic             chan_reg, chan_next;
    logic [TRY_W-1:0] try_reg, try_next;
    logic [15:0]      wait_reg, wait_next;
    logic [7:0]       id_low_reg, id_low_next;
    logic [15:0]      ids_reg [2];
    logic [15:0]      ids_next [2];
    logic             second_reg, second_next;

    result_t          res [2];
    logic [1:0]       n_res;
    logic [16:0]      wait_inc;
    logic             expired;
    logic             do_fail;
    status_t          fail_code;
    logic             do_begin;
    logic             do_finish;
    status_t          fin_status;

    always_comb
    begin
        phase_next = phase_reg;
        op_next = op_reg;
        chan_next = chan_reg;
        try_next = try_reg;
        wait_next = wait_reg;
        id_low_next = id_low_reg;
        ids_next = ids_reg;
        res[0] = '0;
        res[1] = '0;
        n_res = 2'd0;
        do_fail = 1'b0;
        fail_code = ST_OK;
        do_begin = 1'b0;
        do_finish = 1'b0;
        fin_status = ST_OK;
        wait_inc = {1'b0, wait_reg} + 17'd1;
        // A zero timeout expires on the first tick, the same as a timeout of one.
        expired = (wait_inc >= {1'b0, seq_cfg.timeout_ticks});

        if (item_valid)
        begin
            unique case (item.kind)
                KIND_START_RESET, KIND_START_IDENT:
                begin
                    if (phase_reg == PH_IDLE && item.start_ok)
                    begin
                        op_next = (item.kind == KIND_START_IDENT);
                        chan_next = item.channel;
                        try_next = '0;
                        if (item.kind == KIND_START_RESET)
                        begin
                            res[n_res[0]] = make_result(ACT_ENABLE, item.channel, 8'h00,
                                                        ST_OK, 16'h0000);
                            n_res = n_res + 2'd1;
                        end
                        do_begin = 1'b1;
                    end
                end
                KIND_RX_BYTE:
                begin
                    unique case (phase_reg)
                        PH_RST_ACK:
                        begin
                            if (item.is_ack)
                            begin
                                phase_next = PH_RST_BAT;
                                wait_next = '0;
                            end
                            else
                            begin
                                do_fail = 1'b1;
                                fail_code = ST_BAD_ACK;
                            end
                        end
                        PH_RST_BAT:
                        begin
                            if (item.is_bat_pass)
                            begin
                                do_finish = 1'b1;
                            end
                            else
                            begin
                                do_fail = 1'b1;
                                fail_code = ST_BAT_FAIL;
                            end
                        end
                        PH_DIS_ACK:
                        begin
                            if (item.is_ack)
                            begin
                                if (chan_reg)
                                begin
                                    res[n_res[0]] = make_result(ACT_ROUTE, chan_reg, 8'h00,
                                                                ST_OK, 16'h0000);
                                    n_res = n_res + 2'd1;
                                end
                                phase_next = PH_IDF_SEND;
                                wait_next = '0;
                            end
                            else
                            begin
                                do_fail = 1'b1;
                                fail_code = ST_BAD_ACK;
                            end
                        end
                        PH_IDF_ACK:
                        begin
                            if (item.is_ack)
                            begin
                                phase_next = PH_ID_FIRST;
                                wait_next = '0;
                            end
                            else
                            begin
                                do_fail = 1'b1;
                                fail_code = ST_BAD_ACK;
                            end
                        end
                        PH_ID_FIRST:
                        begin
                            id_low_next = item.rx_byte;
                            phase_next = PH_ID_SECOND;
                            wait_next = '0;
                        end
                        PH_ID_SECOND:
                        begin
                            ids_next[chan_reg] = {item.rx_byte, id_low_reg};
                            do_finish = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                KIND_TICK:
                begin
                    unique case (phase_reg)
                        PH_RST_SEND, PH_DIS_SEND, PH_IDF_SEND:
                        begin
                            if (!item.tx_busy)
                            begin
                                unique case (phase_reg)
                                    PH_RST_SEND:
                                    begin
                                        res[n_res[0]] = make_result(ACT_SEND, chan_reg,
                                                                    CMD_RESET, ST_OK, 16'h0000);
                                        phase_next = PH_RST_ACK;
                                    end
                                    PH_DIS_SEND:
                                    begin
                                        res[n_res[0]] = make_result(ACT_SEND, chan_reg,
                                                                    CMD_DISABLE_SCAN, ST_OK,
                                                                    16'h0000);
                                        phase_next = PH_DIS_ACK;
                                    end
                                    default:
                                    begin
                                        res[n_res[0]] = make_result(ACT_SEND, chan_reg,
                                                                    CMD_IDENTIFY, ST_OK,
                                                                    16'h0000);
                                        phase_next = PH_IDF_ACK;
                                    end
                                endcase
                                n_res = n_res + 2'd1;
                                wait_next = '0;
                            end
                            else
                            begin
                                wait_next = wait_inc[15:0];
                                if (expired)
                                begin
                                    do_fail = 1'b1;
                                    fail_code = ST_BUSY;
                                end
                            end
                        end
                        PH_RST_ACK, PH_RST_BAT, PH_DIS_ACK, PH_IDF_ACK:
                        begin
                            wait_next = wait_inc[15:0];
                            if (expired)
                            begin
                                do_fail = 1'b1;
                                fail_code = ST_TIMEOUT;
                            end
                        end
                        PH_ID_FIRST:
                        begin
                            wait_next = wait_inc[15:0];
                            if (expired)
                            begin
                                ids_next[chan_reg] = seq_cfg.id_absent_code;
                                do_finish = 1'b1;
                            end
                        end
                        PH_ID_SECOND:
                        begin
                            wait_next = wait_inc[15:0];
                            if (expired)
                            begin
                                ids_next[chan_reg] = {8'h00, id_low_reg};
                                do_finish = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            endcase
        end

        // A failed try either starts over or reports the failure when tries run out.
        if (do_fail)
        begin
            if ({1'b0, try_reg} + 3'd1 < 3'(MAX_TRIES))
            begin
                try_next = try_reg + 1'b1;
                do_begin = 1'b1;
            end
            else
            begin
                do_finish = 1'b1;
                fin_status = fail_code;
            end
        end

        if (do_begin)
        begin
            if (chan_next)
            begin
                res[n_res[0]] = make_result(ACT_ROUTE, chan_next, 8'h00, ST_OK, 16'h0000);
                n_res = n_res + 2'd1;
            end
            phase_next = op_next ? PH_DIS_SEND : PH_RST_SEND;
            wait_next = '0;
        end

        if (do_finish)
        begin
            phase_next = PH_IDLE;
            wait_next = '0;
            if (op_reg)
            begin
                res[n_res[0]] = make_result(ACT_IDENT_DONE, chan_reg, 8'h00, fin_status,
                                            ids_next[chan_reg]);
            end
            else
            begin
                res[n_res[0]] = make_result(ACT_RESET_DONE, chan_reg, 8'h00, fin_status,
                                            16'h0000);
            end
            n_res = n_res + 2'd1;
        end

        if (n_res == 2'd1)
        begin
            res[0].last = 1'b1;
        end
        else if (n_res == 2'd2)
        begin
            res[1].last = 1'b1;
        end
    end

    // An item with two results is held until both have gone out; the state is committed
    // only when its last result has gone out, so both results see the same state.
    assign out_push = item_valid && (n_res != 2'd0) && !out_full;
    assign out_data = second_reg ? res[1] : res[0];
    assign item_pop = item_valid &&
                      ((n_res == 2'd0) || (!out_full && ((n_res == 2'd1) || second_reg)));

    always_comb
    begin
        second_next = second_reg;
        if (item_valid && (n_res == 2'd2) && !out_full)
        begin
            second_next = !second_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            op_reg <= 1'b0;
            chan_reg <= 1'b0;
            try_reg <= '0;
            wait_reg <= '0;
            id_low_reg <= '0;
            ids_reg[0] <= NO_DEVICE_ID;
            ids_reg[1] <= NO_DEVICE_ID;
            second_reg <= 1'b0;
        end
        else
        begin
            second_reg <= second_next;
            if (item_pop)
            begin
                phase_reg <= phase_next;
                op_reg <= op_next;
                chan_reg <= chan_next;
                try_reg <= try_next;
                wait_reg <= wait_next;
                id_low_reg <= id_low_next;
                ids_reg <= ids_next;
            end
        end
    end

endmodule

// File: tb/ps2_device_bringup_sequencer_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for ps2_device_bringup_sequencer_unit: directed and random reset and
// identify sequences, checked against an in-bench prediction of every result item.
// Depends on ps2db_pkg and the RTL of the block.
module ps2_device_bringup_sequencer_unit_test;
    import ps2db_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES = 300;

    // Predicts the sequencer and checks each result item against the oldest prediction.
    class bringup_scoreboard;
        bit [1:0]  ch_ok;
        bit [15:0] timeout_ticks;
        bit [7:0]  ack_code;
        bit [7:0]  bat_code;
        bit [15:0] absent_id;
        bit [15:0] no_dev_id;

        phase_t    phase;
        bit        identify;
        bit        act_ch;
        bit [1:0]  tries;
        bit [15:0] waited;
        bit [7:0]  id_low;
        bit [15:0] ids [2];

        result_t   batch[$];
        result_t   expected_results[$];
        int        errors;
        int        checked;

        function new();
            ch_ok = 2'b00;
            timeout_ticks = TIMEOUT_RESET;
            ack_code = ACK_RESET;
            bat_code = BAT_PASS_RESET;
            absent_id = ID_ABSENT_RESET;
            no_dev_id = NO_DEVICE_ID;
            phase = PH_IDLE;
            identify = 1'b0;
            act_ch = 1'b0;
            tries = '0;
            waited = '0;
            id_low = '0;
            ids[0] = NO_DEVICE_ID;
            ids[1] = NO_DEVICE_ID;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CHANNEL0_OK:    ch_ok[0] = data[0];
                REG_CHANNEL1_OK:    ch_ok[1] = data[0];
                REG_TIMEOUT_TICKS:  timeout_ticks = data;
                REG_ACK_CODE:       ack_code = data[7:0];
                REG_BAT_PASS_CODE:  bat_code = data[7:0];
                REG_ID_ABSENT_CODE: absent_id = data;
                REG_NO_DEVICE_CODE: no_dev_id = data;
                default: ;
            endcase
        endfunction

        function void emit(action_t act, bit [7:0] tx, status_t st, bit [15:0] id);
            result_t r;
            r.action = act;
            r.out_channel = act_ch;
            r.tx_byte = tx;
            r.status = st;
            r.device_id = id;
            r.last = 1'b0;
            batch.push_back(r);
        endfunction

        function bit wait_expired();
            waited++;
            return waited >= timeout_ticks;
        endfunction

        // Each try on channel 1 starts by routing the next byte to it.
        function void begin_try();
            if (act_ch)
                emit(ACT_ROUTE, 8'h00, ST_OK, 16'h0000);
            phase = identify ? PH_DIS_SEND : PH_RST_SEND;
            waited = '0;
        endfunction

        function void finish(status_t st);
            phase = PH_IDLE;
            waited = '0;
            if (identify)
                emit(ACT_IDENT_DONE, 8'h00, st, ids[act_ch]);
            else
                emit(ACT_RESET_DONE, 8'h00, st, 16'h0000);
        endfunction

        function void fail(status_t st);
            if (int'(tries) + 1 < MAX_TRIES_DEF) begin
                tries++;
                begin_try();
            end
            else begin
                finish(st);
            end
        endfunction

        // Returns 1 when the item is acted on rather than ignored.
        function bit take_item(kind_t k, bit ch, bit [7:0] rx, bit busy);
            bit        acted;
            bit [7:0]  cmd;
            phase_t    nxt_phase;
            result_t   r;
            acted = 1'b0;
            batch.delete();
            case (k)
                KIND_START_RESET, KIND_START_IDENT:
                begin
                    if (phase == PH_IDLE && ch_ok[ch]) begin
                        acted = 1'b1;
                        identify = (k == KIND_START_IDENT);
                        act_ch = ch;
                        tries = '0;
                        if (!identify)
                            emit(ACT_ENABLE, 8'h00, ST_OK, 16'h0000);
                        begin_try();
                    end
                end
                KIND_RX_BYTE:
                begin
                    acted = 1'b1;
                    case (phase)
                        PH_RST_ACK:
                            if (rx == ack_code) begin
                                phase = PH_RST_BAT;
                                waited = '0;
                            end
                            else fail(ST_BAD_ACK);
                        PH_RST_BAT:
                            if (rx == bat_code) finish(ST_OK);
                            else fail(ST_BAT_FAIL);
                        PH_DIS_ACK:
                            if (rx == ack_code) begin
                                if (act_ch)
                                    emit(ACT_ROUTE, 8'h00, ST_OK, 16'h0000);
                                phase = PH_IDF_SEND;
                                waited = '0;
                            end
                            else fail(ST_BAD_ACK);
                        PH_IDF_ACK:
                            if (rx == ack_code) begin
                                phase = PH_ID_FIRST;
                                waited = '0;
                            end
                            else fail(ST_BAD_ACK);
                        PH_ID_FIRST:
                        begin
                            id_low = rx;
                            phase = PH_ID_SECOND;
                            waited = '0;
                        end
                        PH_ID_SECOND:
                        begin
                            ids[act_ch] = {rx, id_low};
                            finish(ST_OK);
                        end
                        default: acted = 1'b0;
                    endcase
                end
                default:
                begin
                    acted = 1'b1;
                    case (phase)
                        PH_RST_SEND, PH_DIS_SEND, PH_IDF_SEND:
                        begin
                            if (!busy) begin
                                if (phase == PH_RST_SEND) begin
                                    cmd = CMD_RESET;
                                    nxt_phase = PH_RST_ACK;
                                end
                                else if (phase == PH_DIS_SEND) begin
                                    cmd = CMD_DISABLE_SCAN;
                                    nxt_phase = PH_DIS_ACK;
                                end
                                else begin
                                    cmd = CMD_IDENTIFY;
                                    nxt_phase = PH_IDF_ACK;
                                end
                                emit(ACT_SEND, cmd, ST_OK, 16'h0000);
                                phase = nxt_phase;
                                waited = '0;
                            end
                            else if (wait_expired()) begin
                                fail(ST_BUSY);
                            end
                        end
                        PH_RST_ACK, PH_RST_BAT, PH_DIS_ACK, PH_IDF_ACK:
                            if (wait_expired()) fail(ST_TIMEOUT);
                        PH_ID_FIRST:
                            if (wait_expired()) begin
                                ids[act_ch] = absent_id;
                                finish(ST_OK);
                            end
                        PH_ID_SECOND:
                            if (wait_expired()) begin
                                ids[act_ch] = {8'h00, id_low};
                                finish(ST_OK);
                            end
                        default: acted = 1'b0;
                    endcase
                end
            endcase
            for (int i = 0; i < batch.size(); i++) begin
                r = batch[i];
                r.last = (i == batch.size() - 1);
                expected_results.push_back(r);
            end
            return acted;
        endfunction

        function void compare_field(string name, int unsigned want_v, int unsigned got_v);
            if (want_v != got_v) begin
                $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                $error("result item with nothing expected: action %0d channel %0d",
                       got.action, got.out_channel);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            checked++;
            compare_field("action", want.action, got.action);
            compare_field("out_channel", want.out_channel, got.out_channel);
            compare_field("tx_byte", want.tx_byte, got.tx_byte);
            compare_field("status", want.status, got.status);
            compare_field("device_id", want.device_id, got.device_id);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  kind = '0;
    logic        channel = 1'b0;
    logic [7:0]  rx_byte = '0;
    logic        tx_busy = 1'b0;
    logic        pop = 1'b0;
    logic        empty;
    logic [2:0]  action;
    logic        out_channel;
    logic [7:0]  tx_byte;
    logic [2:0]  status;
    logic [15:0] device_id;
    logic        last;

    bringup_scoreboard sb;
    int cycle_count = 0;
    bit idle_en = 1'b1;
    bit hold_req = 1'b0;
    int accepted_items = 0;
    int acted_items = 0;

    ps2_device_bringup_sequencer_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .channel     (channel),
        .rx_byte     (rx_byte),
        .tx_busy     (tx_busy),
        .pop         (pop),
        .empty       (empty),
        .action      (action),
        .out_channel (out_channel),
        .tx_byte     (tx_byte),
        .status      (status),
        .device_id   (device_id),
        .last        (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Result side: checks every accepted result item and drives pop for the next cycle.
    initial
    begin : result_side
        int      hold_left;
        result_t got;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && pop && !empty) begin
                got.action = action_t'(action);
                got.out_channel = out_channel;
                got.tx_byte = tx_byte;
                got.status = status_t'(status);
                got.device_id = device_id;
                got.last = last;
                sb.check_result(got);
            end
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end
            else begin
                pop <= idle_en ? ($urandom_range(99) >= 9) : 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles.", cycle_count);
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_item(kind_t k, bit ch, bit [7:0] rx, bit busy);
        while (idle_en && $urandom_range(99) < 9) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        kind <= k;
        channel <= ch;
        rx_byte <= rx;
        tx_busy <= busy;
        @(posedge clk);
        while (full) @(posedge clk);
        accepted_items++;
        if (sb.take_item(k, ch, rx, busy))
            acted_items++;
    endtask

    // Always waits for a clock edge so push is never lowered and raised in one step.
    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0) @(posedge clk);
    endtask

    // Items with no result may still be inside the block once the last result is out.
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(bit ok0, bit ok1, bit [15:0] tmo, bit [7:0] ack, bit [7:0] bat,
                                bit [15:0] absent, bit [15:0] nodev);
        logic [CFG_INDEX_W-1:0] regs [7];
        logic [CFG_DATA_W-1:0]  vals [7];
        regs = '{REG_CHANNEL0_OK, REG_CHANNEL1_OK, REG_TIMEOUT_TICKS, REG_ACK_CODE,
                 REG_BAT_PASS_CODE, REG_ID_ABSENT_CODE, REG_NO_DEVICE_CODE};
        vals = '{{15'd0, ok0}, {15'd0, ok1}, tmo, {8'd0, ack}, {8'd0, bat}, absent, nodev};
        for (int i = 0; i < 7; i++) begin
            cfg_write <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            @(posedge clk);
            sb.write_reg(regs[i], vals[i]);
        end
        cfg_write <= 1'b0;
    endtask

    // Mostly the item that moves the current sequence on, with some wrong bytes, stray
    // items and starts that are ignored.
    task automatic send_random_item();
        int        roll;
        kind_t     k;
        bit        ch;
        bit [7:0]  rx;
        bit        busy;
        roll = $urandom_range(99);
        rx = 8'($urandom_range(255));
        busy = ($urandom_range(99) < 15);
        if ($urandom_range(99) < 10 || sb.ch_ok == 2'b11)
            ch = 1'($urandom_range(1));
        else
            ch = sb.ch_ok[1];
        case (sb.phase)
            PH_IDLE:
                if (roll < 85) k = $urandom_range(1) ? KIND_START_IDENT : KIND_START_RESET;
                else k = $urandom_range(1) ? KIND_TICK : KIND_RX_BYTE;
            PH_RST_SEND, PH_DIS_SEND, PH_IDF_SEND:
                if (roll < 80) k = KIND_TICK;
                else if (roll < 90) k = KIND_RX_BYTE;
                else k = KIND_START_RESET;
            PH_RST_ACK, PH_DIS_ACK, PH_IDF_ACK:
            begin
                if (roll < 75) begin
                    k = KIND_RX_BYTE;
                    rx = sb.ack_code;
                end
                else if (roll < 85) k = KIND_RX_BYTE;
                else if (roll < 97) k = KIND_TICK;
                else k = KIND_START_IDENT;
            end
            PH_RST_BAT:
            begin
                if (roll < 75) begin
                    k = KIND_RX_BYTE;
                    rx = sb.bat_code;
                end
                else if (roll < 87) k = KIND_RX_BYTE;
                else k = KIND_TICK;
            end
            default:
                k = (roll < 65) ? KIND_RX_BYTE : KIND_TICK;
        endcase
        send_item(k, ch, rx, busy);
    endtask

    // Runs until n items have been acted on, then lets the open sequence finish.
    task automatic run_phase(int n);
        int target;
        target = acted_items + n;
        while (acted_items < target) send_random_item();
        while (sb.phase != PH_IDLE) send_random_item();
    endtask

    initial
    begin : stimulus
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both channels are disabled after reset, so all of these are ignored.
        send_item(KIND_START_RESET, 1'b0, 8'h00, 1'b0);
        send_item(KIND_START_IDENT, 1'b1, 8'h00, 1'b0);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b1);
        send_item(KIND_RX_BYTE, 1'b0, 8'hFF, 1'b0);
        settle();

        apply_config(1'b1, 1'b1, 16'd3, ACK_RESET, BAT_PASS_RESET, ID_ABSENT_RESET, NO_DEVICE_ID);
        // Reset on channel 1 with one busy tick and a start while busy.
        send_item(KIND_START_RESET, 1'b1, 8'h00, 1'b0);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b1);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b0);
        send_item(KIND_RX_BYTE, 1'b0, ACK_RESET, 1'b0);
        send_item(KIND_START_IDENT, 1'b0, 8'h00, 1'b0);
        send_item(KIND_RX_BYTE, 1'b0, BAT_PASS_RESET, 1'b0);
        // Identify on channel 0 with a two byte ID at the byte extremes.
        send_item(KIND_START_IDENT, 1'b0, 8'h00, 1'b0);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b0);
        send_item(KIND_RX_BYTE, 1'b0, ACK_RESET, 1'b0);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b0);
        send_item(KIND_RX_BYTE, 1'b0, ACK_RESET, 1'b0);
        send_item(KIND_RX_BYTE, 1'b0, 8'h00, 1'b0);
        send_item(KIND_RX_BYTE, 1'b0, 8'hFF, 1'b0);
        // Identify on channel 1 that runs out of tries and keeps the no-device ID.
        send_item(KIND_START_IDENT, 1'b1, 8'h00, 1'b0);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b0);
        send_item(KIND_RX_BYTE, 1'b0, 8'h12, 1'b0);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b0);
        send_item(KIND_RX_BYTE, 1'b0, 8'h34, 1'b0);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b0);
        send_item(KIND_RX_BYTE, 1'b0, 8'h56, 1'b0);
        settle();

        // The result side stalls for a long stretch at the start so the block backs up.
        apply_config(1'b1, 1'b1, 16'd1, ACK_RESET, BAT_PASS_RESET, ID_ABSENT_RESET,
                     NO_DEVICE_ID);
        hold_req = 1'b1;
        run_phase(75);
        settle();

        // A zero timeout acts like one tick.
        apply_config(1'b1, 1'b0, 16'd0, 8'h00, 8'hFF, 16'h0000, 16'h0000);
        run_phase(38);
        drain_results();
        run_phase(38);
        settle();

        idle_en = 1'b0;
        apply_config(1'b0, 1'b1, 16'd4, 8'hFF, 8'h00, 16'hFFFF, NO_DEVICE_ID);
        run_phase(75);
        settle();
        idle_en = 1'b1;

        apply_config(1'b1, 1'b1, 16'hFFFF, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     16'($urandom_range(65535)), 16'($urandom_range(65535)));
        run_phase(85);
        settle();

        $display("Covered %0d input items (%0d acted on) and %0d result items in six settings,",
                 accepted_items, acted_items, sb.checked);
        $display("with zero and maximum timeouts, a long result stall and a full drain pause.");
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
